[rtl/assert_macros.svh]
// assertion helpers, clocked on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SVM_ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: condition must never hold");

`define SVM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`else

`define SVM_ASSERT_NEVER(name, cond)

`define SVM_ASSERT_IMPL(name, ante, cons)

`endif

`endif

[rtl/svm_pkg.sv]
package svm_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = ADDR_W + 1;
    localparam int DATA_W      = 32;
    localparam int PC_W        = 13;
    localparam int CLEN_W      = 12;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] OP_PUSH = 8'h0A;
    localparam logic [7:0] OP_POP  = 8'h0B;
    localparam logic [7:0] OP_INC  = 8'h0C;
    localparam logic [7:0] OP_DEC  = 8'h0D;
    localparam logic [7:0] OP_JMP  = 8'h0E;
    localparam logic [7:0] OP_JG   = 8'h0F;
    localparam logic [7:0] OP_STOR = 8'h1A;
    localparam logic [7:0] OP_LOAD = 8'h1B;
    localparam logic [7:0] OP_CALL = 8'h1C;
    localparam logic [7:0] OP_HLT  = 8'h1D;
    localparam logic [7:0] OP_ADD  = 8'hA0;
    localparam logic [7:0] OP_SUB  = 8'hB0;
    localparam logic [7:0] OP_MUL  = 8'hC0;
    localparam logic [7:0] OP_DIV  = 8'hD0;
    localparam logic [7:0] OP_MOD  = 8'hE0;
    localparam logic [7:0] OP_SHR  = 8'hF0;
    localparam logic [7:0] OP_SHL  = 8'hA1;
    localparam logic [7:0] OP_XOR  = 8'hB1;
    localparam logic [7:0] OP_AND  = 8'hC1;
    localparam logic [7:0] OP_OR   = 8'hD1;
    localparam logic [7:0] OP_NOT  = 8'hE1;
    localparam logic [7:0] OP_JE   = 8'hF1;
    localparam logic [7:0] OP_JL   = 8'hA2;
    localparam logic [7:0] OP_JNE  = 8'hB2;
    localparam logic [7:0] OP_JLE  = 8'hC2;
    localparam logic [7:0] OP_JGE  = 8'hD2;
    localparam logic [7:0] OP_ALLC = 8'hE2;

    localparam logic [3:0] STS_OK        = 4'd0;
    localparam logic [3:0] STS_HALT      = 4'd1;
    localparam logic [3:0] STS_UNDER     = 4'd2;
    localparam logic [3:0] STS_FULL      = 4'd3;
    localparam logic [3:0] STS_BAD_JUMP  = 4'd4;
    localparam logic [3:0] STS_DST_LOW   = 4'd5;
    localparam logic [3:0] STS_DST_HIGH  = 4'd6;
    localparam logic [3:0] STS_SRC_LOW   = 4'd7;
    localparam logic [3:0] STS_SRC_HIGH  = 4'd8;
    localparam logic [3:0] STS_NEG_ALLOC = 4'd9;
    localparam logic [3:0] STS_ALLOC_OVF = 4'd10;
    localparam logic [3:0] STS_UNDEF     = 4'd11;
    localparam logic [3:0] STS_DIV_ZERO  = 4'd12;

    typedef enum logic [3:0] {
        CL_PUSH,
        CL_POP,
        CL_UNARY,
        CL_JMP,
        CL_CALL,
        CL_COND,
        CL_STOR,
        CL_LOAD,
        CL_HLT,
        CL_ALU,
        CL_DIV,
        CL_ALLOC,
        CL_UNDEF
    } op_class_t;

    typedef struct packed {
        op_class_t          cls;
        logic [7:0]         opcode;
        logic [DATA_W-1:0]  immediate;
    } item_t;

    typedef struct packed {
        logic               start;
        logic               is_mod;
        logic [DATA_W-1:0]  dividend;
        logic [DATA_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DATA_W-1:0]  value;
    } div_rsp_t;

    typedef struct packed {
        logic               below;
        logic               above;
        logic [ADDR_W-1:0]  idx;
    } idx_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH_Y,
        ST_FETCH_Z,
        ST_EXEC,
        ST_DIV,
        ST_STOR_WR,
        ST_REFILL,
        ST_REFILL_CAP,
        ST_ALLOC,
        ST_DONE
    } exec_state_t;

    // signed stack index against a size, negative counts from the top
    function automatic idx_res_t resolve_idx(input logic [DATA_W-1:0] raw,
                                             input logic [SP_W-1:0] size);
        idx_res_t r;
        logic [DATA_W:0] sum;
        r   = '0;
        sum = {raw[DATA_W-1], raw} + {{(DATA_W+1-SP_W){1'b0}}, size};
        if (raw[DATA_W-1])
        begin
            r.below = sum[DATA_W];
            r.idx   = sum[ADDR_W-1:0];
        end
        else
        begin
            r.above = (raw[DATA_W-1:SP_W] != '0) || (raw[SP_W-1:0] >= size);
            r.idx   = raw[ADDR_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] alu_result(input logic [7:0] op,
                                                     input logic [DATA_W-1:0] y,
                                                     input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] r;
        case (op)
            OP_ADD:  r = y + x;
            OP_SUB:  r = y - x;
            OP_MUL:  r = y * x;
            OP_SHR:  r = DATA_W'($signed(y) >>> x[4:0]);
            OP_SHL:  r = y << x[4:0];
            OP_XOR:  r = y ^ x;
            OP_AND:  r = y & x;
            default: r = y | x;
        endcase
        return r;
    endfunction

endpackage

[rtl/stack_vm_execute_unit.sv]
// Execute unit of a 32-bit integer stack machine: each input beat carries the opcode
// (and push immediate) fetched at the last reported next_pc, and each beat yields one
// result beat with status, next_pc, top of stack, depth and done. A two-entry input
// queue decouples the handshake from the executor, which runs one instruction at a
// time against a 256-entry single-port-write, registered-read stack memory with the
// top entry cached in a register. Instructions pass ST_FETCH_Y, ST_FETCH_Z, ST_EXEC
// and ST_DONE to the output register; conditional jumps, load and store add refill
// states that reread the top from memory; div and mod wait in ST_DIV for the radix-2
// divider; alloc zeroes new entries one by one in ST_ALLOC. Host mode (stopped, or
// next_pc at or past code_length) lets push and pop load and drain the stack. The user
// must write code_length only while idle; the unit does not enforce it.
`include "assert_macros.svh"

module stack_vm_execute_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              code_length_wr_en,
    input  logic [svm_pkg::CLEN_W-1:0]        code_length_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        opcode,
    input  logic signed [svm_pkg::DATA_W-1:0] immediate,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [3:0]                        status,
    output logic [svm_pkg::PC_W-1:0]          next_pc,
    output logic signed [svm_pkg::DATA_W-1:0] top_value,
    output logic [svm_pkg::SP_W-1:0]          stack_depth,
    output logic                              done_res
);

    logic           q_valid;
    logic           q_pop;
    svm_pkg::item_t q_item;

    svm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .immediate (immediate),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    svm_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .code_length_wr_en   (code_length_wr_en),
        .code_length_wr_data (code_length_wr_data),
        .q_valid             (q_valid),
        .q_pop               (q_pop),
        .q_item              (q_item),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .status              (status),
        .next_pc             (next_pc),
        .top_value           (top_value),
        .stack_depth         (stack_depth),
        .done_res            (done_res)
    );

    `SVM_ASSERT_NEVER(a_depth_bound, out_valid && (stack_depth > 9'd256))
    `SVM_ASSERT_NEVER(a_status_bound, out_valid && (status > svm_pkg::STS_DIV_ZERO))
    `SVM_ASSERT_IMPL(a_empty_top_zero, out_valid && (stack_depth == '0), top_value == '0)
    `SVM_ASSERT_IMPL(a_error_is_done, out_valid && (status >= svm_pkg::STS_UNDER), done_res)

endmodule

[rtl/svm_ram.sv]
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/svm_front.sv]
module svm_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   opcode,
    input  logic signed [svm_pkg::DATA_W-1:0] immediate,
    output logic                         q_valid,
    input  logic                         q_pop,
    output svm_pkg::item_t               q_item
);

    svm_pkg::item_t ent_reg [svm_pkg::QUEUE_DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    svm_pkg::op_class_t cls;
    logic           push;

    always_comb
    begin
        case (opcode)
            svm_pkg::OP_PUSH: cls = svm_pkg::CL_PUSH;
            svm_pkg::OP_POP:  cls = svm_pkg::CL_POP;
            svm_pkg::OP_INC, svm_pkg::OP_DEC, svm_pkg::OP_NOT: cls = svm_pkg::CL_UNARY;
            svm_pkg::OP_JMP:  cls = svm_pkg::CL_JMP;
            svm_pkg::OP_CALL: cls = svm_pkg::CL_CALL;
            svm_pkg::OP_JG, svm_pkg::OP_JL, svm_pkg::OP_JE,
            svm_pkg::OP_JNE, svm_pkg::OP_JLE, svm_pkg::OP_JGE: cls = svm_pkg::CL_COND;
            svm_pkg::OP_STOR: cls = svm_pkg::CL_STOR;
            svm_pkg::OP_LOAD: cls = svm_pkg::CL_LOAD;
            svm_pkg::OP_HLT:  cls = svm_pkg::CL_HLT;
            svm_pkg::OP_ADD, svm_pkg::OP_SUB, svm_pkg::OP_MUL, svm_pkg::OP_SHR,
            svm_pkg::OP_SHL, svm_pkg::OP_XOR, svm_pkg::OP_AND,
            svm_pkg::OP_OR:   cls = svm_pkg::CL_ALU;
            svm_pkg::OP_DIV, svm_pkg::OP_MOD: cls = svm_pkg::CL_DIV;
            svm_pkg::OP_ALLC: cls = svm_pkg::CL_ALLOC;
            default:          cls = svm_pkg::CL_UNDEF;
        endcase
    end

    assign in_stall = (cnt_reg == 2'(svm_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= '{cls: cls, opcode: opcode, immediate: immediate};
        end
    end

endmodule

[rtl/svm_div.sv]
module svm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  svm_pkg::div_req_t  req,
    output svm_pkg::div_rsp_t  rsp
);

    localparam int W = svm_pkg::DATA_W;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] quo_reg, quo_next;
    logic [W-1:0] dvs_reg, dvs_next;
    logic         neg_q_reg, neg_q_next;
    logic         neg_r_reg, neg_r_next;
    logic         mod_reg, mod_next;
    logic [W:0]   shifted;
    logic [W:0]   diff;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        mod_next   = mod_reg;
        shifted    = {rem_reg, quo_reg[W-1]};
        diff       = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = 6'(W);
            rem_next   = '0;
            quo_next   = req.dividend[W-1] ? -req.dividend : req.dividend;
            dvs_next   = req.divisor[W-1] ? -req.divisor : req.divisor;
            neg_q_next = req.dividend[W-1] ^ req.divisor[W-1];
            neg_r_next = req.dividend[W-1];
            mod_next   = req.is_mod;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        mod_reg   <= mod_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = mod_reg ? (neg_r_reg ? -rem_reg : rem_reg)
                               : (neg_q_reg ? -quo_reg : quo_reg);

endmodule

[rtl/svm_back.sv]
module svm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              code_length_wr_en,
    input  logic [svm_pkg::CLEN_W-1:0]        code_length_wr_data,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  svm_pkg::item_t                    q_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [3:0]                        status,
    output logic [svm_pkg::PC_W-1:0]          next_pc,
    output logic signed [svm_pkg::DATA_W-1:0] top_value,
    output logic [svm_pkg::SP_W-1:0]          stack_depth,
    output logic                              done_res
);

    localparam int W  = svm_pkg::DATA_W;
    localparam int AW = svm_pkg::ADDR_W;
    localparam int SW = svm_pkg::SP_W;
    localparam int PW = svm_pkg::PC_W;

    svm_pkg::exec_state_t state_reg, state_next;
    svm_pkg::item_t       item_reg, item_next;
    logic [SW-1:0]        sp_reg, sp_next;
    logic [PW-1:0]        pc_reg, pc_next;
    logic                 stopped_reg, stopped_next;
    logic [svm_pkg::CLEN_W-1:0] clen_reg, clen_next;
    logic [W-1:0]         top_reg, top_next;
    logic [W-1:0]         y_reg, y_next;
    logic [W-1:0]         z_reg, z_next;
    logic [3:0]           status_reg, status_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]        cnt_reg, cnt_next;
    logic [AW-1:0]        dst_reg, dst_next;
    logic                 out_valid_reg, out_valid_next;
    logic [3:0]           out_status_reg;
    logic [PW-1:0]        out_pc_reg;
    logic [W-1:0]         out_top_reg;
    logic [SW-1:0]        out_depth_reg;
    logic                 out_done_reg;
    logic                 out_load;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [W-1:0]         ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [W-1:0]         ram_rdata;

    svm_pkg::div_req_t    div_req;
    svm_pkg::div_rsp_t    div_rsp;

    logic [SW-1:0]        sp_m1, sp_m2, sp_m3;
    logic [PW-1:0]        pc_p1;
    logic                 idle_mode;
    logic                 bad_target;
    logic                 holds;
    logic [SW:0]          alloc_sum;
    svm_pkg::idx_res_t    res_a, res_b, res_l;
    logic [W-1:0]         x;

    svm_ram #(
        .WIDTH (W),
        .DEPTH (svm_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    svm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign x          = top_reg;
    assign sp_m1      = sp_reg - SW'(1);
    assign sp_m2      = sp_reg - SW'(2);
    assign sp_m3      = sp_reg - SW'(3);
    assign pc_p1      = pc_reg + PW'(1);
    assign idle_mode  = stopped_reg || (pc_reg >= {1'b0, clen_reg});
    assign bad_target = x[W-1] || (x[W-1:svm_pkg::CLEN_W] != '0)
                        || (x[svm_pkg::CLEN_W-1:0] >= clen_reg);
    assign alloc_sum  = {1'b0, sp_m1} + {1'b0, x[SW-1:0]};
    assign res_a      = svm_pkg::resolve_idx(x, sp_m2);
    assign res_b      = svm_pkg::resolve_idx(y_reg, sp_m2);
    assign res_l      = svm_pkg::resolve_idx(x, sp_m1);

    always_comb
    begin
        case (item_reg.opcode)
            svm_pkg::OP_JG:  holds = $signed(z_reg) >  $signed(y_reg);
            svm_pkg::OP_JL:  holds = $signed(z_reg) <  $signed(y_reg);
            svm_pkg::OP_JE:  holds = z_reg == y_reg;
            svm_pkg::OP_JNE: holds = z_reg != y_reg;
            svm_pkg::OP_JLE: holds = $signed(z_reg) <= $signed(y_reg);
            default:         holds = $signed(z_reg) >= $signed(y_reg);
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        sp_next      = sp_reg;
        pc_next      = pc_reg;
        stopped_next = stopped_reg;
        clen_next    = clen_reg;
        top_next     = top_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        status_next  = status_reg;
        ptr_next     = ptr_reg;
        cnt_next     = cnt_reg;
        dst_next     = dst_reg;
        ram_we       = 1'b0;
        ram_waddr    = sp_m1[AW-1:0];
        ram_wdata    = top_reg;
        ram_raddr    = sp_m2[AW-1:0];
        q_pop        = 1'b0;
        out_load     = 1'b0;
        div_req      = '{start: 1'b0, is_mod: item_reg.opcode == svm_pkg::OP_MOD,
                         dividend: y_reg, divisor: x};

        if (code_length_wr_en)
        begin
            clen_next = code_length_wr_data;
        end

        case (state_reg)
            svm_pkg::ST_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = svm_pkg::ST_FETCH_Y;
                end
            end
            svm_pkg::ST_FETCH_Y:
            begin
                y_next     = ram_rdata;
                ram_raddr  = sp_m3[AW-1:0];
                state_next = svm_pkg::ST_FETCH_Z;
            end
            svm_pkg::ST_FETCH_Z:
            begin
                z_next     = ram_rdata;
                state_next = svm_pkg::ST_EXEC;
            end
            svm_pkg::ST_EXEC:
            begin
                state_next  = svm_pkg::ST_DONE;
                status_next = svm_pkg::STS_OK;
                if (idle_mode)
                begin
                    case (item_reg.cls)
                        svm_pkg::CL_PUSH:
                        begin
                            if (sp_reg == SW'(svm_pkg::STACK_DEPTH))
                            begin
                                status_next = svm_pkg::STS_FULL;
                            end
                            else
                            begin
                                ram_we   = (sp_reg != '0);
                                top_next = item_reg.immediate;
                                sp_next  = sp_reg + SW'(1);
                            end
                        end
                        svm_pkg::CL_POP:
                        begin
                            if (sp_reg == '0)
                            begin
                                status_next = svm_pkg::STS_UNDER;
                            end
                            else
                            begin
                                sp_next  = sp_m1;
                                top_next = y_reg;
                            end
                        end
                        default:
                        begin
                            status_next = svm_pkg::STS_HALT;
                        end
                    endcase
                end
                else
                begin
                    case (item_reg.cls)
                        svm_pkg::CL_PUSH:
                        begin
                            if (sp_reg == SW'(svm_pkg::STACK_DEPTH))
                            begin
                                status_next = svm_pkg::STS_FULL;
                            end
                            else
                            begin
                                ram_we   = (sp_reg != '0);
                                top_next = item_reg.immediate;
                                sp_next  = sp_reg + SW'(1);
                                pc_next  = pc_reg + PW'(5);
                            end
                        end
                        svm_pkg::CL_POP:
                        begin
                            if (sp_reg == '0)
                            begin
                                status_next = svm_pkg::STS_UNDER;
                            end
                            else
                            begin
                                sp_next  = sp_m1;
                                top_next = y_reg;
                                pc_next  = pc_p1;
                            end
                        end
                        svm_pkg::CL_UNARY:
                        begin
                            if (sp_reg == '0)
                            begin
                                status_next = svm_pkg::STS_UNDER;
                            end
                            else
                            begin
                                case (item_reg.opcode)
                                    svm_pkg::OP_INC: top_next = x + W'(1);
                                    svm_pkg::OP_DEC: top_next = x - W'(1);
                                    default:         top_next = ~x;
                                endcase
                                pc_next = pc_p1;
                            end
                        end
                        svm_pkg::CL_JMP, svm_pkg::CL_CALL:
                        begin
                            if (sp_reg == '0)
                            begin
                                status_next = svm_pkg::STS_UNDER;
                            end
                            else if (bad_target)
                            begin
                                status_next = svm_pkg::STS_BAD_JUMP;
                            end
                            else
                            begin
                                pc_next = x[PW-1:0];
                                if (item_reg.cls == svm_pkg::CL_JMP)
                                begin
                                    sp_next  = sp_m1;
                                    top_next = y_reg;
                                end
                                else
                                begin
                                    top_next = {{(W-PW){1'b0}}, pc_p1};
                                end
                            end
                        end
                        svm_pkg::CL_COND:
                        begin
                            if (sp_reg < SW'(3))
                            begin
                                status_next = svm_pkg::STS_UNDER;
                            end
                            else if (bad_target)
                            begin
                                status_next = svm_pkg::STS_BAD_JUMP;
                            end
                            else
                            begin
                                sp_next    = sp_m3;
                                pc_next    = holds ? x[PW-1:0] : pc_p1;
                                state_next = svm_pkg::ST_REFILL;
                            end
                        end
                        svm_pkg::CL_STOR:
                        begin
                            if (sp_reg < SW'(2))
                            begin
                                status_next = svm_pkg::STS_UNDER;
                            end
                            else if (res_a.below)
                            begin
                                status_next = svm_pkg::STS_DST_LOW;
                            end
                            else if (res_a.above)
                            begin
                                status_next = svm_pkg::STS_DST_HIGH;
                            end
                            else if (res_b.below)
                            begin
                                status_next = svm_pkg::STS_SRC_LOW;
                            end
                            else if (res_b.above)
                            begin
                                status_next = svm_pkg::STS_SRC_HIGH;
                            end
                            else
                            begin
                                ram_raddr  = res_b.idx;
                                dst_next   = res_a.idx;
                                sp_next    = sp_m2;
                                pc_next    = pc_p1;
                                state_next = svm_pkg::ST_STOR_WR;
                            end
                        end
                        svm_pkg::CL_LOAD:
                        begin
                            if (sp_reg == '0)
                            begin
                                status_next = svm_pkg::STS_UNDER;
                            end
                            else if (res_l.below)
                            begin
                                status_next = svm_pkg::STS_SRC_LOW;
                            end
                            else if (res_l.above)
                            begin
                                status_next = svm_pkg::STS_SRC_HIGH;
                            end
                            else
                            begin
                                ram_raddr  = res_l.idx;
                                pc_next    = pc_p1;
                                state_next = svm_pkg::ST_REFILL_CAP;
                            end
                        end
                        svm_pkg::CL_HLT:
                        begin
                            status_next  = svm_pkg::STS_HALT;
                            stopped_next = 1'b1;
                            pc_next      = pc_p1;
                        end
                        svm_pkg::CL_ALU:
                        begin
                            if (sp_reg < SW'(2))
                            begin
                                status_next = svm_pkg::STS_UNDER;
                            end
                            else
                            begin
                                top_next = svm_pkg::alu_result(item_reg.opcode, y_reg, x);
                                sp_next  = sp_m1;
                                pc_next  = pc_p1;
                            end
                        end
                        svm_pkg::CL_DIV:
                        begin
                            if (sp_reg < SW'(2))
                            begin
                                status_next = svm_pkg::STS_UNDER;
                            end
                            else if (x == '0)
                            begin
                                status_next = svm_pkg::STS_DIV_ZERO;
                            end
                            else
                            begin
                                div_req.start = 1'b1;
                                state_next    = svm_pkg::ST_DIV;
                            end
                        end
                        svm_pkg::CL_ALLOC:
                        begin
                            if (sp_reg == '0)
                            begin
                                status_next = svm_pkg::STS_UNDER;
                            end
                            else if (x[W-1])
                            begin
                                status_next = svm_pkg::STS_NEG_ALLOC;
                            end
                            else if ((x[W-1:SW] != '0) || alloc_sum[SW:SW-1] != 2'b00)
                            begin
                                status_next = svm_pkg::STS_ALLOC_OVF;
                            end
                            else if (x[SW-1:0] == '0)
                            begin
                                sp_next  = sp_m1;
                                top_next = y_reg;
                                pc_next  = pc_p1;
                            end
                            else
                            begin
                                sp_next    = alloc_sum[SW-1:0];
                                top_next   = '0;
                                pc_next    = pc_p1;
                                ptr_next   = sp_m1[AW-1:0];
                                cnt_next   = x[AW-1:0] - AW'(1);
                                state_next = svm_pkg::ST_ALLOC;
                            end
                        end
                        default:
                        begin
                            status_next = svm_pkg::STS_UNDEF;
                        end
                    endcase
                    if (status_next >= svm_pkg::STS_UNDER)
                    begin
                        stopped_next = 1'b1;
                    end
                end
            end
            svm_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    top_next   = div_rsp.value;
                    sp_next    = sp_m1;
                    pc_next    = pc_p1;
                    state_next = svm_pkg::ST_DONE;
                end
            end
            svm_pkg::ST_STOR_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = dst_reg;
                ram_wdata  = ram_rdata;
                state_next = svm_pkg::ST_REFILL;
            end
            svm_pkg::ST_REFILL:
            begin
                ram_raddr  = sp_m1[AW-1:0];
                state_next = svm_pkg::ST_REFILL_CAP;
            end
            svm_pkg::ST_REFILL_CAP:
            begin
                top_next   = ram_rdata;
                state_next = svm_pkg::ST_DONE;
            end
            svm_pkg::ST_ALLOC:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = svm_pkg::ST_DONE;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_reg;
                    ram_wdata = '0;
                    ptr_next  = ptr_reg + AW'(1);
                    cnt_next  = cnt_reg - AW'(1);
                end
            end
            svm_pkg::ST_DONE:
            begin
                out_load   = 1'b1;
                state_next = svm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = svm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svm_pkg::ST_IDLE;
            sp_reg        <= '0;
            pc_reg        <= '0;
            stopped_reg   <= 1'b0;
            clen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            pc_reg        <= pc_next;
            stopped_reg   <= stopped_next;
            clen_reg      <= clen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        top_reg    <= top_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        status_reg <= status_next;
        ptr_reg    <= ptr_next;
        cnt_reg    <= cnt_next;
        dst_reg    <= dst_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_pc_reg     <= pc_reg;
            out_top_reg    <= (sp_reg != '0) ? top_reg : '0;
            out_depth_reg  <= sp_reg;
            out_done_reg   <= idle_mode;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign next_pc     = out_pc_reg;
    assign top_value   = out_top_reg;
    assign stack_depth = out_depth_reg;
    assign done_res    = out_done_reg;

endmodule
